### rtl/edr_pkg.sv
// Shared types, codes and helpers for the port error-disable recovery block.
package edr_pkg;

    localparam int SOURCES   = 8;
    localparam int FUNC_W    = 2;
    localparam int PORT_W    = 5;
    localparam int SRC_W     = 4;
    localparam int ACT_W     = 2;
    localparam int SMASK_W   = 8;
    localparam int CD_W      = 17;
    localparam int DMASK_W   = 32;
    localparam int CFG_IDX_W = 2;

    // func codes
    localparam logic [FUNC_W-1:0] FUNC_ERROR   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RECOVER = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CONFIG  = 2'd3;

    // action codes
    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DISABLE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TIMER   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CMD     = 2'd3;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DETECT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd2;

    localparam logic [CD_W-1:0] INTERVAL_RST = 17'd300;
    localparam logic [CD_W-1:0] CD_ONE       = 17'd1;
    localparam logic [SRC_W-1:0] SRC_NONE    = 4'd0;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PORT_W-1:0] port;
        logic [SRC_W-1:0]  err_src;
    } t_in;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [PORT_W-1:0]  out_port;
        logic [SRC_W-1:0]   out_src;
        logic [DMASK_W-1:0] disabled_mask;
        logic               last;
    } t_out;

    // classified command between front and back
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PORT_W-1:0] port;
        logic [SRC_W-1:0]  src;
        logic              in_range;
        logic              hit;
    } t_cmd;

    typedef struct packed {
        logic [SMASK_W-1:0] recover_mask;
        logic [CD_W-1:0]    recover_interval;
    } t_cfg;

    // source s (1..SOURCES) selected by mask bit s-1; anything else never matches
    function automatic logic src_in(input logic [SMASK_W-1:0] mask,
                                    input logic [SRC_W-1:0] s);
        logic ok;
        logic [SRC_W-1:0] sm1;
        ok  = (s >= 4'd1) && (int'(s) <= SOURCES) && (s <= 4'd8);
        sm1 = s - 4'd1;
        return ok && mask[sm1[2:0]];
    endfunction

endpackage

### rtl/edr_front.sv
// Front end: accepts input beats, classifies them and queues commands for the back end.
module edr_front #(
    parameter int NPORT = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  edr_pkg::t_in                       i_in_data,
    output logic                               o_in_stall,
    input  logic [edr_pkg::SMASK_W-1:0]        i_detect_mask,
    output logic                               o_cmd_valid,
    output edr_pkg::t_cmd                      o_cmd,
    input  logic                               i_cmd_pop
);

    edr_pkg::t_cmd r_q [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    edr_pkg::t_cmd cls;
    logic          push;

    always_comb begin
        cls.func     = i_in_data.func;
        cls.port     = i_in_data.port;
        cls.src      = i_in_data.err_src;
        cls.in_range = int'(i_in_data.port) < NPORT;
        cls.hit      = cls.in_range && edr_pkg::src_in(i_detect_mask, i_in_data.err_src);
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        case ({push, i_cmd_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= !r_wr;
            end
            if (i_cmd_pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cls;
        end
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> (r_cnt != 2'd0))
        else $error("pop from empty command queue");

endmodule

### rtl/edr_back.sv
// Back end: per-port state, single-beat commands and the port sweep for tick and config.
module edr_back #(
    parameter int NPORT = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  edr_pkg::t_cfg i_cfg,
    input  logic          i_cmd_valid,
    input  edr_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_out_valid,
    output edr_pkg::t_out o_out_data,
    input  logic          i_out_stall
);

    localparam int IW = (NPORT > 1) ? $clog2(NPORT) : 1;
    localparam int PW = edr_pkg::PORT_W;
    localparam int DW = edr_pkg::DMASK_W;
    localparam int CW = edr_pkg::CD_W;
    localparam int SW = edr_pkg::SRC_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    t_state                     r_state;
    logic [edr_pkg::FUNC_W-1:0] r_op;
    logic [IW-1:0]              r_idx;
    logic [NPORT-1:0]           r_off;
    logic [NPORT-1:0]           r_trig;
    logic [NPORT-1:0]           r_seen;
    logic [SW-1:0]              r_cause [NPORT];
    logic [SW-1:0]              r_armed [NPORT];
    logic [CW-1:0]              r_cd    [NPORT];
    logic                       r_hold_valid;
    edr_pkg::t_out              r_hold;
    logic                       r_out_valid;
    edr_pkg::t_out              r_out;

    logic [NPORT-1:0] n_off;
    logic [IW-1:0]    sel;
    logic             rd_off, rd_trig, rd_seen;
    logic [SW-1:0]    rd_cause, rd_armed;
    logic [CW-1:0]    rd_cd;
    logic             nw_off, nw_trig, nw_seen;
    logic [SW-1:0]    nw_cause, nw_armed;
    logic [CW-1:0]    nw_cd;
    logic             we, sweep_emit, do_single, step_ok, single, out_free;
    logic             rec_cause, rec_armed;
    logic [edr_pkg::ACT_W-1:0] emit_act;
    logic [SW-1:0]    emit_src;
    logic             push_out;
    edr_pkg::t_out    push_data;
    edr_pkg::t_out    sweep_res;

    assign sel      = (r_state == S_SWEEP) ? r_idx : i_cmd.port[IW-1:0];
    assign rd_off   = r_off[sel];
    assign rd_trig  = r_trig[sel];
    assign rd_seen  = r_seen[sel];
    assign rd_cause = r_cause[sel];
    assign rd_armed = r_armed[sel];
    assign rd_cd    = r_cd[sel];

    assign single    = (i_cmd.func == edr_pkg::FUNC_ERROR) ||
                       (i_cmd.func == edr_pkg::FUNC_RECOVER);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign rec_cause = edr_pkg::src_in(i_cfg.recover_mask, rd_cause);
    assign rec_armed = edr_pkg::src_in(i_cfg.recover_mask, rd_armed);

    // next record of the selected port
    always_comb begin
        we         = 1'b0;
        do_single  = 1'b0;
        sweep_emit = 1'b0;
        step_ok    = 1'b1;
        emit_act   = edr_pkg::ACT_NONE;
        emit_src   = edr_pkg::SRC_NONE;
        nw_off     = rd_off;
        nw_trig    = rd_trig;
        nw_seen    = rd_seen;
        nw_cause   = rd_cause;
        nw_armed   = rd_armed;
        nw_cd      = rd_cd;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && single && out_free) begin
                    do_single = 1'b1;
                    if (i_cmd.func == edr_pkg::FUNC_ERROR) begin
                        if (i_cmd.hit) begin
                            we       = 1'b1;
                            nw_cause = i_cmd.src;
                            nw_off   = 1'b1;
                            nw_trig  = 1'b1;
                            emit_act = edr_pkg::ACT_DISABLE;
                            emit_src = i_cmd.src;
                        end
                    end else if (i_cmd.in_range) begin
                        we       = 1'b1;
                        nw_off   = 1'b0;
                        nw_trig  = 1'b0;
                        nw_seen  = 1'b0;
                        nw_cause = edr_pkg::SRC_NONE;
                        nw_armed = edr_pkg::SRC_NONE;
                        nw_cd    = '0;
                        if (rd_off) begin
                            emit_act = edr_pkg::ACT_CMD;
                            emit_src = rd_cause;
                        end
                    end
                end
            end
            S_SWEEP: begin
                if (rd_off) begin
                    if (r_op == edr_pkg::FUNC_TICK) begin
                        // first sweep after an error arms the countdown if the cause may recover
                        if ((rd_trig != rd_seen) && rec_cause) begin
                            nw_cd    = i_cfg.recover_interval;
                            nw_armed = rd_cause;
                            nw_seen  = rd_trig;
                        end
                        if (rec_cause && (nw_cd != '0)) begin
                            nw_cd = nw_cd - edr_pkg::CD_ONE;
                            if (nw_cd == '0) begin
                                sweep_emit = 1'b1;
                                emit_act   = edr_pkg::ACT_TIMER;
                                emit_src   = rd_cause;
                                nw_off     = 1'b0;
                                nw_trig    = 1'b0;
                                nw_seen    = 1'b0;
                                nw_cause   = edr_pkg::SRC_NONE;
                                nw_armed   = edr_pkg::SRC_NONE;
                            end
                        end
                    end else begin
                        // config applied: clamp, then arm or cancel
                        if (rd_cd > i_cfg.recover_interval) begin
                            nw_cd = i_cfg.recover_interval;
                        end
                        if (rd_armed != edr_pkg::SRC_NONE) begin
                            if (!rec_armed) begin
                                nw_cd    = '0;
                                nw_armed = edr_pkg::SRC_NONE;
                                nw_trig  = 1'b0;
                                nw_seen  = 1'b0;
                            end
                        end else if (rec_cause) begin
                            nw_cd    = i_cfg.recover_interval;
                            nw_armed = rd_cause;
                            nw_trig  = 1'b1;
                            nw_seen  = 1'b1;
                        end
                    end
                    // a second recovery needs the held one moved out first
                    step_ok = !(sweep_emit && r_hold_valid && !out_free);
                    we      = step_ok;
                end
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_off = r_off;
        if (we) begin
            n_off[sel] = nw_off;
        end
    end

    always_comb begin
        sweep_res.action        = emit_act;
        sweep_res.out_port      = PW'(r_idx);
        sweep_res.out_src       = emit_src;
        sweep_res.disabled_mask = DW'(n_off);
        sweep_res.last          = 1'b0;

        push_out  = 1'b0;
        push_data = r_hold;
        case (r_state)
            S_IDLE: begin
                if (do_single) begin
                    push_out                = 1'b1;
                    push_data.action        = emit_act;
                    push_data.out_port      = i_cmd.port;
                    push_data.out_src       = emit_src;
                    push_data.disabled_mask = DW'(n_off);
                    push_data.last          = 1'b1;
                end
            end
            S_SWEEP: begin
                if (step_ok && sweep_emit && r_hold_valid) begin
                    push_out  = 1'b1;
                    push_data = r_hold;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    push_out = 1'b1;
                    if (r_hold_valid) begin
                        push_data      = r_hold;
                        push_data.last = 1'b1;
                    end else begin
                        push_data.action        = edr_pkg::ACT_NONE;
                        push_data.out_port      = '0;
                        push_data.out_src       = edr_pkg::SRC_NONE;
                        push_data.disabled_mask = DW'(r_off);
                        push_data.last          = 1'b1;
                    end
                end
            end
            default: begin
                push_out = 1'b0;
            end
        endcase
    end

    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid && (!single || out_free);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // control and per-port state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_op         <= edr_pkg::FUNC_TICK;
            r_idx        <= '0;
            r_off        <= '0;
            r_trig       <= '0;
            r_seen       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int p = 0; p < NPORT; p++) begin
                r_cause[p] <= '0;
                r_armed[p] <= '0;
                r_cd[p]    <= '0;
            end
        end else begin
            r_off <= n_off;
            if (we) begin
                r_trig[sel]  <= nw_trig;
                r_seen[sel]  <= nw_seen;
                r_cause[sel] <= nw_cause;
                r_armed[sel] <= nw_armed;
                r_cd[sel]    <= nw_cd;
            end
            if (push_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && !single) begin
                        r_op    <= i_cmd.func;
                        r_idx   <= '0;
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (step_ok) begin
                        if (sweep_emit) begin
                            r_hold_valid <= 1'b1;
                        end
                        if (r_idx == IW'(NPORT - 1)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_hold_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (push_out) begin
            r_out <= push_data;
        end
        if ((r_state == S_SWEEP) && step_ok && sweep_emit) begin
            r_hold <= sweep_res;
        end
    end

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_valid)
        else $error("held result left over after sweep");

    a_hold_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> (r_hold.action == edr_pkg::ACT_TIMER))
        else $error("held result is not a timer recovery");

    a_off_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_off |-> (rd_cause != edr_pkg::SRC_NONE))
        else $error("disabled port without a cause");

    a_sweep_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |->
            ((r_op == edr_pkg::FUNC_TICK) || (r_op == edr_pkg::FUNC_CONFIG)))
        else $error("sweep started for a single-beat command");

endmodule

### rtl/port_error_disable_recovery.sv
// Top level of the port error-disable recovery controller: config registers and front/back.
//
// Usage:
//   Input channel (i_in_valid / i_in_data / o_in_stall) carries one beat per event:
//   error event, one-second tick, recover command or config applied.
//   Output channel (o_out_valid / o_out_data / i_out_stall) returns one or more result
//   beats per input; the final one has last set.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) writes
//   detect_mask, recover_mask and recover_interval; it is always ready. Write it only
//   while the block is idle.
// Timing:
//   A two-entry command queue decouples the front end from the back end.
//   Error and recover commands need no sweep; their result is registered in the output register.
//   Tick and config walk every port once, PORTS (max 32), in a one-port-per-cycle sweep
//   over the per-port state, which pauses only as described below.
//   A stalled output holds its beat; the sweep pauses only when a second recovery
//   is found while the output is stalled and the one-beat hold register is full.
// Reset:
//   Synchronous, active low. All ports normal, all timers and flags cleared,
//   masks zero, interval 300. No clearing pass is needed.
module port_error_disable_recovery #(
    parameter int PORTS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  edr_pkg::t_in                        i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output edr_pkg::t_out                       o_out_data,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [edr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [edr_pkg::CD_W-1:0]            i_cfg_data
);

    // port field is 5 bits, so at most 32 ports are addressable
    localparam int NPORT = (PORTS < 32) ? PORTS : 32;

    logic [edr_pkg::SMASK_W-1:0] r_detect_mask;
    logic [edr_pkg::SMASK_W-1:0] r_recover_mask;
    logic [edr_pkg::CD_W-1:0]    r_recover_interval;
    edr_pkg::t_cfg               cfg;
    logic                        cmd_valid;
    logic                        cmd_pop;
    edr_pkg::t_cmd               cmd;

    assign o_cfg_ready = 1'b1;

    // config write: index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect_mask      <= '0;
            r_recover_mask     <= '0;
            r_recover_interval <= edr_pkg::INTERVAL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                edr_pkg::REG_DETECT:   r_detect_mask      <= i_cfg_data[edr_pkg::SMASK_W-1:0];
                edr_pkg::REG_RECOVER:  r_recover_mask     <= i_cfg_data[edr_pkg::SMASK_W-1:0];
                edr_pkg::REG_INTERVAL: r_recover_interval <= i_cfg_data;
                default: begin
                    r_recover_interval <= r_recover_interval;
                end
            endcase
        end
    end

    assign cfg.recover_mask     = r_recover_mask;
    assign cfg.recover_interval = r_recover_interval;

    // front: accept and classify (port range, detect hit)
    edr_front #(
        .NPORT(NPORT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .o_in_stall    (o_in_stall),
        .i_detect_mask (r_detect_mask),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    // back: per-port state, sweep, result beats
    edr_back #(
        .NPORT(NPORT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

### dv/port_error_disable_recovery_test.sv
// Self-checking testbench for the port error-disable recovery controller.
`timescale 1ns / 1ps

module port_error_disable_recovery_test;
    import edr_pkg::*;

    localparam int NPORTS          = 32;
    // one full port walk plus the front queue and output register, with margin
    localparam int SWEEP_WAIT      = NPORTS + 8;
    localparam int BEATS_PER_PHASE = 48;
    localparam int RANDOM_PHASES   = 8;

    // ------------------------------------------------------------------
    // Clock, reset and DUT hookup. All inputs start at known values.
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in                  in_data   = '0;
    logic                 in_stall;
    logic                 out_valid;
    t_out                 out_data;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_DETECT;
    logic [CD_W-1:0]      cfg_data  = '0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    port_error_disable_recovery #(
        .PORTS(NPORTS)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predicted controller state: register copies and per-port records.
    // ------------------------------------------------------------------
    logic [SMASK_W-1:0] detect_bits;
    logic [SMASK_W-1:0] recover_bits;
    logic [CD_W-1:0]    interval_len;

    logic               port_down    [NPORTS];
    logic [SRC_W-1:0]   down_cause   [NPORTS];
    logic [SRC_W-1:0]   armed_cause  [NPORTS];
    logic [CD_W-1:0]    secs_left    [NPORTS];
    logic               trip_pending [NPORTS];
    logic               trip_taken   [NPORTS];

    t_out due_results[$];   // port actions still owed by the DUT, oldest first
    t_in  pend_events[$];   // events not yet offered to the DUT

    int issued_beats   = 0;
    int accepted_beats = 0;
    int fail_count     = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    bit calm_in        = 1'b0;   // phase runs the input side without gaps
    bit calm_out       = 1'b0;   // phase runs the output side without stalls

    // Mostly zero, sometimes a short pause, rarely a long one.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(8, 40);
    endfunction

    // Sources outside 1..SOURCES never match any mask.
    function automatic logic src_enabled(logic [SMASK_W-1:0] mask, logic [SRC_W-1:0] s);
        if (s == SRC_NONE || int'(s) > SOURCES || int'(s) > SMASK_W) return 1'b0;
        return mask[int'(s) - 1];
    endfunction

    function automatic void wipe_port(int p);
        port_down[p]    = 1'b0;
        down_cause[p]   = SRC_NONE;
        armed_cause[p]  = SRC_NONE;
        secs_left[p]    = '0;
        trip_pending[p] = 1'b0;
        trip_taken[p]   = 1'b0;
    endfunction

    function automatic void reset_model();
        detect_bits  = '0;
        recover_bits = '0;
        interval_len = INTERVAL_RST;
        for (int p = 0; p < NPORTS; p++) wipe_port(p);
    endfunction

    // Queue one result beat; the mask reflects state after this action.
    function automatic void post_result(logic [ACT_W-1:0] act, int p, logic [SRC_W-1:0] s);
        t_out r;
        r.action        = act;
        r.out_port      = PORT_W'(p);
        r.out_src       = s;
        r.disabled_mask = '0;
        for (int i = 0; i < NPORTS; i++) r.disabled_mask[i] = port_down[i];
        r.last          = 1'b0;
        due_results.push_back(r);
    endfunction

    // Advance the predicted state by one event and queue its result beats.
    function automatic void apply_event(t_in e);
        int               first;
        int               p;
        logic             rec;
        logic [SRC_W-1:0] s;
        t_out             tail;
        first = due_results.size();
        p     = int'(e.port);
        case (e.func)
            FUNC_ERROR: begin
                // re-error on a down port overwrites the cause; a running timer keeps going
                if (src_enabled(detect_bits, e.err_src)) begin
                    down_cause[p]   = e.err_src;
                    port_down[p]    = 1'b1;
                    trip_pending[p] = 1'b1;
                    post_result(ACT_DISABLE, p, e.err_src);
                end
            end
            FUNC_TICK: begin
                for (int q = 0; q < NPORTS; q++) begin
                    if (port_down[q]) begin
                        rec = src_enabled(recover_bits, down_cause[q]);
                        // first sweep after a new trip arms the countdown
                        if (trip_pending[q] != trip_taken[q] && rec) begin
                            secs_left[q]   = interval_len;
                            armed_cause[q] = down_cause[q];
                            trip_taken[q]  = trip_pending[q];
                        end
                        // a zero countdown never expires
                        if (rec && secs_left[q] != '0) begin
                            secs_left[q] = secs_left[q] - CD_ONE;
                            if (secs_left[q] == '0) begin
                                s = down_cause[q];
                                wipe_port(q);
                                post_result(ACT_TIMER, q, s);
                            end
                        end
                    end
                end
            end
            FUNC_RECOVER: begin
                if (port_down[p]) begin
                    s = down_cause[p];
                    wipe_port(p);
                    post_result(ACT_CMD, p, s);
                end else begin
                    wipe_port(p);
                end
            end
            FUNC_CONFIG: begin
                for (int q = 0; q < NPORTS; q++) begin
                    if (port_down[q]) begin
                        if (secs_left[q] > interval_len) secs_left[q] = interval_len;
                        if (armed_cause[q] != SRC_NONE) begin
                            // recovery no longer allowed: cancel it
                            if (!src_enabled(recover_bits, armed_cause[q])) begin
                                secs_left[q]    = '0;
                                armed_cause[q]  = SRC_NONE;
                                trip_pending[q] = 1'b0;
                                trip_taken[q]   = 1'b0;
                            end
                        end else if (src_enabled(recover_bits, down_cause[q])) begin
                            secs_left[q]    = interval_len;
                            armed_cause[q]  = down_cause[q];
                            trip_pending[q] = 1'b1;
                            trip_taken[q]   = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        // nothing changed: one idle beat, port echoed for error and recover only
        if (due_results.size() == first)
            post_result(ACT_NONE,
                        (e.func == FUNC_ERROR || e.func == FUNC_RECOVER) ? p : 0, SRC_NONE);
        tail      = due_results[due_results.size() - 1];
        tail.last = 1'b1;
        due_results[due_results.size() - 1] = tail;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: pops pending events, random gaps between beats.
    // A stalled beat holds both valid and payload.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) gap_left = calm_in ? 0 : pause_len();
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pend_events.size() != 0) begin
                in_valid <= 1'b1;
                in_data  <= pend_events.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure: random stall runs, short mostly.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (stall_left == 0 && !calm_out) stall_left = pause_len();
            out_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: tracks register writes, predicts on each accepted input beat,
    // then checks each accepted output beat against the oldest prediction.
    // Prediction runs first so a same-edge result still finds its entry.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_out want;
        if (!rst_n) begin
            reset_model();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DETECT:   detect_bits  = cfg_data[SMASK_W-1:0];
                    REG_RECOVER:  recover_bits = cfg_data[SMASK_W-1:0];
                    REG_INTERVAL: interval_len = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                accepted_beats++;
                apply_event(in_data);
            end
            if (out_valid && !out_stall) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result beat: action %0d port %0d src %0d",
                           out_data.action, out_data.out_port, out_data.out_src);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (out_data.action !== want.action) begin
                        $error("action: expected %0d, got %0d", want.action, out_data.action);
                        fail_count++;
                    end
                    if (out_data.out_port !== want.out_port) begin
                        $error("out_port: expected %0d, got %0d",
                               want.out_port, out_data.out_port);
                        fail_count++;
                    end
                    if (out_data.out_src !== want.out_src) begin
                        $error("out_src: expected %0d, got %0d", want.out_src, out_data.out_src);
                        fail_count++;
                    end
                    if (out_data.disabled_mask !== want.disabled_mask) begin
                        $error("disabled_mask: expected %h, got %h",
                               want.disabled_mask, out_data.disabled_mask);
                        fail_count++;
                    end
                    if (out_data.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, out_data.last);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_event(logic [FUNC_W-1:0] f, int p, int s);
        t_in e;
        e.func    = f;
        e.port    = PORT_W'(p);
        e.err_src = SRC_W'(s);
        pend_events.push_back(e);
        issued_beats++;
    endfunction

    // Error/tick heavy so trips get armed and timers actually run out;
    // ports lean toward a small group so recovers and re-errors collide.
    function automatic void queue_random_event();
        int               r;
        int               p;
        int               s;
        logic [FUNC_W-1:0] f;
        r = $urandom_range(0, 99);
        p = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, NPORTS - 1);
        s = $urandom_range(0, 15);
        if (r < 45) begin
            f = FUNC_TICK;
        end else if (r < 78) begin
            f = FUNC_ERROR;
            if ($urandom_range(0, 99) < 85) s = $urandom_range(1, SOURCES);
        end else if (r < 92) begin
            f = FUNC_RECOVER;
        end else begin
            f = FUNC_CONFIG;
        end
        queue_event(f, p, s);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CD_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic [SMASK_W-1:0] det, logic [SMASK_W-1:0] rec,
                            logic [CD_W-1:0] ivl);
        write_reg(REG_DETECT, CD_W'(det));
        write_reg(REG_RECOVER, CD_W'(rec));
        write_reg(REG_INTERVAL, ivl);
    endtask

    // Block idle: every beat taken, every result back, then a sweep's worth of slack.
    task automatic settle();
        while (accepted_beats != issued_beats || due_results.size() != 0) @(posedge clk);
        repeat (SWEEP_WAIT) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [SMASK_W-1:0] det;
        logic [SMASK_W-1:0] rec;
        logic [CD_W-1:0]    ivl;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: nothing detects, nothing recovers
        queue_event(FUNC_ERROR, 0, 1);
        queue_event(FUNC_TICK, 0, 0);
        queue_event(FUNC_RECOVER, 31, 0);      // recover on a normal port
        queue_event(FUNC_CONFIG, 0, 0);
        settle();

        // all sources detect, only 1..4 recover, one-tick timer
        set_regs(8'hFF, 8'h0F, 17'd1);
        queue_event(FUNC_ERROR, 0, 1);
        queue_event(FUNC_ERROR, 31, 8);        // top port, top source, no auto-recovery
        queue_event(FUNC_ERROR, 1, 3);
        queue_event(FUNC_ERROR, 2, 4);
        queue_event(FUNC_ERROR, 4, 0);         // no source
        queue_event(FUNC_ERROR, 4, 9);         // sources past the range
        queue_event(FUNC_ERROR, 4, 15);
        queue_event(FUNC_ERROR, 0, 2);         // error on an already disabled port
        queue_event(FUNC_TICK, 0, 0);          // ports 0..2 recover in one sweep
        queue_event(FUNC_RECOVER, 31, 0);
        queue_event(FUNC_RECOVER, 7, 0);
        queue_event(FUNC_ERROR, 30, 5);
        queue_event(FUNC_CONFIG, 0, 0);
        settle();

        // zero interval: armed timers never expire, only a command recovers
        set_regs(8'hFF, 8'hFF, 17'd0);
        queue_event(FUNC_CONFIG, 0, 0);        // arms port 30 with a zero countdown
        queue_event(FUNC_ERROR, 3, 6);
        queue_event(FUNC_TICK, 0, 0);
        queue_event(FUNC_TICK, 0, 0);
        queue_event(FUNC_RECOVER, 3, 0);
        queue_event(FUNC_RECOVER, 30, 0);
        settle();

        // random phases; port state carries across so clamps and cancels bite
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    det = 8'hFF; rec = 8'hFF; ivl = 17'd30;
                end
                1: begin
                    det = SMASK_W'($urandom); rec = SMASK_W'($urandom);
                    ivl = CD_W'($urandom_range(1, 4));
                end
                2: begin
                    det = 8'hFF; rec = 8'h00; ivl = 17'd86400;
                end
                3: begin
                    det = SMASK_W'($urandom); rec = 8'hFF; ivl = 17'h1FFFF;
                end
                4: begin
                    det = 8'hFF; rec = SMASK_W'($urandom); ivl = 17'd30;
                end
                5: begin
                    det = 8'h00; rec = 8'hFF; ivl = 17'd2;
                end
                6: begin
                    det = 8'hFF; rec = 8'hFF; ivl = 17'd0;
                end
                default: begin
                    det = SMASK_W'($urandom); rec = SMASK_W'($urandom);
                    ivl = CD_W'($urandom_range(1, 40));
                end
            endcase
            set_regs(det, rec, ivl);
            calm_in  = ($urandom_range(0, 3) == 0);
            calm_out = ($urandom_range(0, 3) == 0);
            // new masks take effect through a config-applied event
            queue_event(FUNC_CONFIG, $urandom_range(0, NPORTS - 1), $urandom_range(0, 15));
            repeat (BEATS_PER_PHASE - 1) queue_random_event();
            settle();
        end

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
